>>> sv/pid_pkg.sv
// Shared widths, register indexes and controller states of the PID block.
package pid_pkg;

    // Field and state widths
    localparam int ERR_W      = 32;
    localparam int GAIN_W     = 32;
    localparam int DT_W       = 24;
    localparam int INTEG_W    = 48;
    localparam int DIFF_W     = ERR_W + 1;
    localparam int MAG_W      = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    // Product widths of the serial multipliers
    localparam int PROD_P_W   = GAIN_W + MAG_W;
    localparam int PROD_INC_W = MAG_W + DT_W;
    localparam int PROD_I_W   = GAIN_W + INTEG_W;
    localparam int PROD_D_W   = GAIN_W + MAG_W;

    // Rounding shifts back to the target formats
    localparam int P_SHIFT    = 16;
    localparam int INC_SHIFT  = 8;
    localparam int I_SHIFT    = 48;

    // Term widths
    localparam int PM_W       = PROD_P_W - P_SHIFT;
    localparam int IM_W       = PROD_I_W - I_SHIFT;
    localparam int DQ_W       = 49;
    localparam int SUM_W      = 51;

    // Reset values of the output limits
    localparam logic [CFG_DATA_W-1:0] LO_RESET = 32'h8000_0000;
    localparam logic [CFG_DATA_W-1:0] HI_RESET = 32'h7FFF_FFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KP = 3'd0,
        CFG_KI = 3'd1,
        CFG_KD = 3'd2,
        CFG_LO = 3'd3,
        CFG_HI = 3'd4
    } t_cfg_idx;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_MUL1,
        ST_ROUND,
        ST_INTEG,
        ST_LOAD2,
        ST_MUL2,
        ST_TERMS,
        ST_SUM,
        ST_CLAMP
    } t_state;

endpackage

>>> sv/pid_ifs.sv
// Valid/ready channel interfaces for the PID input items and results.
interface pid_in_if;
    import pid_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [ERR_W-1:0] error_value;
    logic [DT_W-1:0]         time_step;

    modport source (output valid, output error_value, output time_step, input ready);
    modport sink   (input valid, input error_value, input time_step, output ready);
endinterface

interface pid_out_if;
    import pid_pkg::*;
    logic                    valid;
    logic                    ready;
    logic signed [ERR_W-1:0] drive_value;
    logic                    clamped;

    modport source (output valid, output drive_value, output clamped, input ready);
    modport sink   (input valid, input drive_value, input clamped, output ready);
endinterface

>>> sv/pid_smul.sv
// Bit-serial unsigned shift-add multiplier, one multiplier bit per cycle.
module pid_smul #(
    parameter int A_W = 32,
    parameter int B_W = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [A_W-1:0]     i_a,
    input  logic [B_W-1:0]     i_b,
    output logic               o_busy,
    output logic [A_W+B_W-1:0] o_prod
);
    localparam int CNT_W = $clog2(B_W + 1);

    logic [A_W-1:0]     r_a;
    logic [A_W+B_W-1:0] r_acc;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_busy;
    logic [A_W:0]       w_sum;
    logic [A_W+B_W-1:0] n_acc;

    // Add the multiplicand when the current multiplier bit is set, then shift right
    always_comb begin
        w_sum = {1'b0, r_acc[A_W+B_W-1:B_W]} + (r_acc[0] ? {1'b0, r_a} : {(A_W+1){1'b0}});
        n_acc = {w_sum, r_acc[B_W-1:1]};
    end

    // Sequence the B_W steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(B_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Load operands and advance the accumulator
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_a;
            r_acc <= {{A_W{1'b0}}, i_b};
        end else if (r_busy) begin
            r_acc <= n_acc;
        end
    end

    assign o_busy = r_busy;
    assign o_prod = r_acc;

endmodule

>>> sv/pid_sdiv.sv
// Bit-serial restoring divider for the derivative term, rounded, with saturation.
module pid_sdiv (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [pid_pkg::PROD_D_W-1:0] i_num,
    input  logic [pid_pkg::DT_W-1:0]     i_den,
    output logic                         o_busy,
    output logic [pid_pkg::DQ_W-1:0]     o_quot
);
    import pid_pkg::*;

    // Dividend is num * 2^9; quotient bits below 2^49 are developed serially
    localparam int STEPS  = DQ_W;
    localparam int HI_LSB = PROD_D_W - DT_W;
    localparam int PAD    = STEPS - HI_LSB;
    localparam int CNT_W  = $clog2(STEPS + 1);

    logic [DT_W-1:0]  r_rem;
    logic [DT_W-1:0]  r_den;
    logic [STEPS-1:0] r_shf;
    logic             r_sat;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;

    logic [DT_W:0]    w_trial;
    logic [DT_W:0]    w_diff;
    logic             w_ge;
    logic [DT_W-1:0]  n_rem;
    logic [STEPS:0]   w_round;

    // One trial subtraction per cycle
    always_comb begin
        w_trial = {r_rem, r_shf[STEPS-1]};
        w_ge    = (w_trial >= {1'b0, r_den});
        w_diff  = w_trial - {1'b0, r_den};
        n_rem   = w_ge ? w_diff[DT_W-1:0] : w_trial[DT_W-1:0];
        w_round = {1'b0, r_shf} + (STEPS+1)'(1);
    end

    // Sequence the quotient steps
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(STEPS);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    // Load the dividend high part as the first remainder; shift quotient bits in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= i_num[PROD_D_W-1:HI_LSB];
            r_shf <= {i_num[HI_LSB-1:0], {PAD{1'b0}}};
            r_den <= i_den;
            r_sat <= (i_num[PROD_D_W-1:HI_LSB] >= i_den);
        end else if (r_busy) begin
            r_rem <= n_rem;
            r_shf <= {r_shf[STEPS-2:0], w_ge};
        end
    end

    // Round half up on the extra quotient bit; hold at 2^48 on overflow
    assign o_quot = r_sat ? {1'b1, {(DQ_W-1){1'b0}}} : w_round[STEPS:1];
    assign o_busy = r_busy;

endmodule

>>> sv/pid_controller_with_clamp.sv
// Parallel-form PID step with saturating integral and clamped output, top level.
// Each transfer on i_item brings a Q16.16 error and a Q0.24 time step; one
// result per item leaves on o_result as a Q16.16 drive value with a clamp
// flag. Items are handled one at a time: the next item is accepted only after
// the current result is loaded into the output register. The time per item is
// set by the bit-serial multiply for the P, increment and D products, followed
// by the bit-serial multiply of the integral gain by the updated integral (the
// 49-step derivative division runs beside it), plus the sequencing states.
// A finished result waits in the output register, and the next item is taken
// while it waits; a second result stalls until the first one is transferred.
// The user must write gains and limits through the i_cfg port while the block
// is idle; the block itself does not enforce this.
module pid_controller_with_clamp (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pid_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [pid_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pid_in_if.sink                         i_item,
    pid_out_if.source                      o_result
);
    import pid_pkg::*;

    // Configuration and persistent state
    logic [GAIN_W-1:0]     r_kp, r_ki, r_kd;
    logic [CFG_DATA_W-1:0] r_lo, r_hi;
    logic [INTEG_W-1:0]    r_integ;
    logic [ERR_W-1:0]      r_prev;

    // Per-item working registers
    logic [ERR_W-1:0]      r_err;
    logic [DT_W-1:0]       r_dt;
    logic [DIFF_W-1:0]     r_diff;
    logic                  r_p_neg, r_inc_neg, r_d_neg, r_i_neg, r_dt_zero;
    logic [PM_W-1:0]       r_p_mag, r_p;
    logic [INTEG_W-1:0]    r_inc_mag;
    logic [IM_W-1:0]       r_i_mag;
    logic [SUM_W-1:0]      r_pd, r_sum;
    logic [ERR_W-1:0]      r_drive;
    logic                  r_clamped;
    logic                  r_out_valid;

    t_state r_state, n_state;

    // Controller outputs
    logic w_ready, w_start1, w_start_div, w_start_i, w_out_load;
    logic w_in_acc, w_out_acc;

    // Unit connections
    logic [MAG_W-1:0]      w_err_mag, w_kp_mag, w_kd_mag, w_ki_mag, w_diff_mag;
    logic [INTEG_W-1:0]    w_integ_mag;
    logic [PROD_P_W-1:0]   w_prod_p;
    logic [PROD_INC_W-1:0] w_prod_inc;
    logic [PROD_I_W-1:0]   w_prod_i;
    logic [PROD_D_W-1:0]   w_prod_d;
    logic [DQ_W-1:0]       w_quot;
    logic                  w_busy_p, w_busy_inc, w_busy_i, w_busy_d, w_busy_div;

    // Datapath intermediates
    logic [INTEG_W+1:0]    w_inc_x, w_integ_s;
    logic [INTEG_W-1:0]    n_integ;
    logic [PM_W-1:0]       n_p;
    logic [DQ_W-1:0]       w_d_mag;
    logic [SUM_W-1:0]      w_p_ext, w_d_x, w_i_x, w_lo_ext, w_hi_ext;
    logic                  w_below, w_above;

    assign w_in_acc  = i_item.valid && w_ready;
    assign w_out_acc = r_out_valid && o_result.ready;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:  if (i_item.valid) n_state = ST_LOAD;
            ST_LOAD:  n_state = ST_MUL1;
            ST_MUL1:  if (!w_busy_p && !w_busy_inc && !w_busy_d) n_state = ST_ROUND;
            ST_ROUND: n_state = ST_INTEG;
            ST_INTEG: n_state = ST_LOAD2;
            ST_LOAD2: n_state = ST_MUL2;
            ST_MUL2:  if (!w_busy_i && !w_busy_div) n_state = ST_TERMS;
            ST_TERMS: n_state = ST_SUM;
            ST_SUM:   n_state = ST_CLAMP;
            ST_CLAMP: if (!r_out_valid) n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    // Controller outputs
    always_comb begin
        w_ready     = 1'b0;
        w_start1    = 1'b0;
        w_start_div = 1'b0;
        w_start_i   = 1'b0;
        w_out_load  = 1'b0;
        case (r_state)
            ST_IDLE:  w_ready     = 1'b1;
            ST_LOAD:  w_start1    = 1'b1;
            ST_ROUND: w_start_div = 1'b1;
            ST_LOAD2: w_start_i   = 1'b1;
            ST_CLAMP: w_out_load  = !r_out_valid;
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Operand magnitudes
    always_comb begin
        w_err_mag   = r_err[ERR_W-1] ? (~r_err + 1'b1) : r_err;
        w_kp_mag    = r_kp[GAIN_W-1] ? (~r_kp + 1'b1) : r_kp;
        w_kd_mag    = r_kd[GAIN_W-1] ? (~r_kd + 1'b1) : r_kd;
        w_ki_mag    = r_ki[GAIN_W-1] ? (~r_ki + 1'b1) : r_ki;
        w_diff_mag  = r_diff[DIFF_W-1] ? MAG_W'(~r_diff + 1'b1) : r_diff[MAG_W-1:0];
        w_integ_mag = r_integ[INTEG_W-1] ? (~r_integ + 1'b1) : r_integ;
    end

    pid_smul #(.A_W(GAIN_W), .B_W(MAG_W)) u_mul_p (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start1),
        .i_a(w_kp_mag), .i_b(w_err_mag), .o_busy(w_busy_p), .o_prod(w_prod_p)
    );

    pid_smul #(.A_W(MAG_W), .B_W(DT_W)) u_mul_inc (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start1),
        .i_a(w_err_mag), .i_b(r_dt), .o_busy(w_busy_inc), .o_prod(w_prod_inc)
    );

    pid_smul #(.A_W(GAIN_W), .B_W(MAG_W)) u_mul_d (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start1),
        .i_a(w_kd_mag), .i_b(w_diff_mag), .o_busy(w_busy_d), .o_prod(w_prod_d)
    );

    pid_smul #(.A_W(GAIN_W), .B_W(INTEG_W)) u_mul_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start_i),
        .i_a(w_ki_mag), .i_b(w_integ_mag), .o_busy(w_busy_i), .o_prod(w_prod_i)
    );

    pid_sdiv u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(w_start_div),
        .i_num(w_prod_d), .i_den(r_dt), .o_busy(w_busy_div), .o_quot(w_quot)
    );

    // Integral update with saturation at the accumulator range
    always_comb begin
        w_inc_x   = {2'b00, r_inc_mag} ^ {(INTEG_W+2){r_inc_neg}};
        w_integ_s = {{2{r_integ[INTEG_W-1]}}, r_integ} + w_inc_x + (INTEG_W+2)'(r_inc_neg);
        if (w_integ_s[INTEG_W+1:INTEG_W-1] == 3'b000 ||
            w_integ_s[INTEG_W+1:INTEG_W-1] == 3'b111) begin
            n_integ = w_integ_s[INTEG_W-1:0];
        end else if (w_integ_s[INTEG_W+1]) begin
            n_integ = {1'b1, {(INTEG_W-1){1'b0}}};
        end else begin
            n_integ = {1'b0, {(INTEG_W-1){1'b1}}};
        end
        n_p = r_p_neg ? (~r_p_mag + 1'b1) : r_p_mag;
    end

    // Term combination and clamp compares
    always_comb begin
        w_d_mag  = r_dt_zero ? '0 : w_quot;
        w_p_ext  = {{(SUM_W-PM_W){r_p[PM_W-1]}}, r_p};
        w_d_x    = {{(SUM_W-DQ_W){1'b0}}, w_d_mag} ^ {SUM_W{r_d_neg}};
        w_i_x    = {{(SUM_W-IM_W){1'b0}}, r_i_mag} ^ {SUM_W{r_i_neg}};
        w_lo_ext = {{(SUM_W-CFG_DATA_W){r_lo[CFG_DATA_W-1]}}, r_lo};
        w_hi_ext = {{(SUM_W-CFG_DATA_W){r_hi[CFG_DATA_W-1]}}, r_hi};
        w_below  = ($signed(r_sum) < $signed(w_lo_ext));
        w_above  = ($signed(r_sum) > $signed(w_hi_ext));
    end

    // Configuration registers and persistent state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp    <= '0;
            r_ki    <= '0;
            r_kd    <= '0;
            r_lo    <= LO_RESET;
            r_hi    <= HI_RESET;
            r_integ <= '0;
            r_prev  <= '0;
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_KP:  r_kp <= i_cfg_data;
                    CFG_KI:  r_ki <= i_cfg_data;
                    CFG_KD:  r_kd <= i_cfg_data;
                    CFG_LO:  r_lo <= i_cfg_data;
                    CFG_HI:  r_hi <= i_cfg_data;
                    default: begin
                    end
                endcase
            end
            if (w_in_acc) begin
                r_prev <= i_item.error_value;
            end
            if (r_state == ST_INTEG) begin
                r_integ <= n_integ;
            end
        end
    end

    // Per-item datapath registers
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_err     <= i_item.error_value;
            r_dt      <= i_item.time_step;
            r_dt_zero <= (i_item.time_step == '0);
            r_diff    <= {i_item.error_value[ERR_W-1], i_item.error_value}
                         - {r_prev[ERR_W-1], r_prev};
        end
        if (w_start1) begin
            r_p_neg   <= r_kp[GAIN_W-1] ^ r_err[ERR_W-1];
            r_inc_neg <= r_err[ERR_W-1];
            r_d_neg   <= r_kd[GAIN_W-1] ^ r_diff[DIFF_W-1];
        end
        if (r_state == ST_ROUND) begin
            r_p_mag   <= w_prod_p[PROD_P_W-1:P_SHIFT] + PM_W'(w_prod_p[P_SHIFT-1]);
            r_inc_mag <= w_prod_inc[PROD_INC_W-1:INC_SHIFT]
                         + INTEG_W'(w_prod_inc[INC_SHIFT-1]);
        end
        if (r_state == ST_INTEG) begin
            r_p <= n_p;
        end
        if (w_start_i) begin
            r_i_neg <= r_ki[GAIN_W-1] ^ r_integ[INTEG_W-1];
        end
        if (r_state == ST_TERMS) begin
            r_i_mag <= w_prod_i[PROD_I_W-1:I_SHIFT] + IM_W'(w_prod_i[I_SHIFT-1]);
            r_pd    <= w_p_ext + w_d_x + SUM_W'(r_d_neg);
        end
        if (r_state == ST_SUM) begin
            r_sum <= r_pd + w_i_x + SUM_W'(r_i_neg);
        end
        if (w_out_load) begin
            if (w_below) begin
                r_drive   <= r_lo;
                r_clamped <= 1'b1;
            end else if (w_above) begin
                r_drive   <= r_hi;
                r_clamped <= 1'b1;
            end else begin
                r_drive   <= r_sum[ERR_W-1:0];
                r_clamped <= 1'b0;
            end
        end
    end

    // Hold the result until its transfer completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    assign i_item.ready         = w_ready;
    assign o_result.valid       = r_out_valid;
    assign o_result.drive_value = r_drive;
    assign o_result.clamped     = r_clamped;

endmodule

>>> sim/tb_pid_controller_with_clamp.sv
// Self-checking testbench for the clamped parallel-form PID step.
`timescale 1ns / 1ps

module tb_pid_controller_with_clamp;
    import pid_pkg::*;

    typedef logic signed [127:0] t_wide;

    typedef struct packed {
        logic signed [ERR_W-1:0] err;
        logic [DT_W-1:0]         dt;
    } t_sample;

    typedef struct packed {
        logic signed [ERR_W-1:0] drive;
        logic                    clamped;
    } t_drive;

    typedef enum int {RDY_ALWAYS, RDY_HALF, RDY_SPARSE, RDY_RARE} t_ready_mode;

    localparam t_wide ACC_MAX        = (t_wide'(1) << (INTEG_W - 1)) - 1;
    localparam t_wide ACC_MIN        = -(t_wide'(1) << (INTEG_W - 1));
    localparam int    WATCHDOG_LIMIT = 8000;
    localparam int    HOLD_CYCLES    = 800;
    localparam int    RAND_PHASES    = 8;
    localparam int    PHASE_ITEMS    = 150;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = CFG_KP;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    pid_in_if  item_if ();
    pid_out_if result_if ();

    pid_controller_with_clamp dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_item      (item_if),
        .o_result    (result_if)
    );

    // Controller copy: gains, limits and the carried state
    logic signed [GAIN_W-1:0]  kp, ki, kd;
    logic signed [ERR_W-1:0]   lo_limit, hi_limit;
    logic signed [INTEG_W-1:0] integ;
    logic signed [ERR_W-1:0]   prev_err;

    t_sample sample_queue[$];
    t_drive  drive_queue[$];

    int  n_issued       = 0;
    int  n_accepted     = 0;
    int  mismatch_count = 0;
    int  idle_cycles    = 0;
    int  gap_left       = 0;
    int  burst_left     = 0;
    int  hold_left      = 0;
    int  mode_left      = 0;
    bit  item_taken     = 1'b0;
    bit  stall_armed    = 1'b0;
    bit  stall_done     = 1'b0;
    t_ready_mode ready_mode = RDY_ALWAYS;

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic t_wide magnitude(t_wide v);
        return (v < 0) ? -v : v;
    endfunction

    // Round v / 2^sh to nearest, ties away from zero
    function automatic t_wide round_half_away(t_wide v, int sh);
        t_wide m;
        m = (magnitude(v) + (t_wide'(1) << (sh - 1))) >> sh;
        return (v < 0) ? -m : m;
    endfunction

    // Advance the controller copy by one step and return the clamped drive
    function automatic t_drive predict_drive(logic signed [ERR_W-1:0] err,
                                             logic [DT_W-1:0] dt);
        t_wide  err_w, dt_w, kp_w, ki_w, kd_w, acc, diff, prod, quo, rem, dm;
        t_wide  p_term, i_term, d_term, total, lo_w, hi_w;
        t_drive res;
        err_w = err;
        dt_w  = dt;
        kp_w  = kp;
        ki_w  = ki;
        kd_w  = kd;
        lo_w  = lo_limit;
        hi_w  = hi_limit;

        p_term = round_half_away(kp_w * err_w, P_SHIFT);

        // saturating integral update, used by the I term of this step
        acc = t_wide'(integ) + round_half_away(err_w * dt_w, INC_SHIFT);
        if (acc > ACC_MAX)
            acc = ACC_MAX;
        else if (acc < ACC_MIN)
            acc = ACC_MIN;
        integ  = acc[INTEG_W-1:0];
        i_term = round_half_away(ki_w * acc, I_SHIFT);

        // derivative over the time step; hold huge quotients at 2^48
        diff = err_w - t_wide'(prev_err);
        if (dt_w == 0) begin
            d_term = 0;
        end else begin
            prod = magnitude(kd_w) * magnitude(diff);
            quo  = prod / dt_w;
            rem  = prod % dt_w;
            if (quo >= (t_wide'(1) << 40))
                dm = t_wide'(1) << 48;
            else
                dm = quo * 256 + (2 * rem * 256 + dt_w) / (2 * dt_w);
            d_term = ((kd_w < 0) != (diff < 0)) ? -dm : dm;
        end
        prev_err = err;

        // lower limit wins when the limits are inverted
        total       = p_term + i_term + d_term;
        res.clamped = 1'b1;
        if (total < lo_w)
            res.drive = lo_limit;
        else if (total > hi_w)
            res.drive = hi_limit;
        else begin
            res.drive   = total[ERR_W-1:0];
            res.clamped = 1'b0;
        end
        return res;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return 32'h8000_0000;
            1:       return 32'h7FFF_FFFF;
            2:       return '0;
            3:       return $urandom();
            default: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
        endcase
    endfunction

    // Write all five registers in turn and update the copy
    task automatic load_config(input logic [CFG_DATA_W-1:0] kp_v, ki_v, kd_v, lo_v, hi_v);
        t_cfg_idx              regs[5] = '{CFG_KP, CFG_KI, CFG_KD, CFG_LO, CFG_HI};
        logic [CFG_DATA_W-1:0] vals[5];
        vals = '{kp_v, ki_v, kd_v, lo_v, hi_v};
        for (int k = 0; k < 5; k++) begin
            @(negedge clk);
            cfg_we    = 1'b1;
            cfg_index = regs[k];
            cfg_data  = vals[k];
        end
        @(negedge clk);
        cfg_we   = 1'b0;
        kp       = kp_v;
        ki       = ki_v;
        kd       = kd_v;
        lo_limit = lo_v;
        hi_limit = hi_v;
    endtask

    task automatic queue_item(input logic [ERR_W-1:0] err, input logic [DT_W-1:0] dt);
        sample_queue.push_back(t_sample'{err, dt});
        n_issued++;
    endtask

    // Wait until every item is taken and every drive value has arrived
    task automatic drain();
        while (n_accepted != n_issued || drive_queue.size() != 0)
            @(posedge clk);
    endtask

    // Item driver: offer items in bursts with random gaps between them
    always @(negedge clk) begin
        t_sample s;
        if (!rst_n) begin
            item_if.valid <= 1'b0;
        end else if (!item_if.valid || item_taken) begin
            if (gap_left > 0 || sample_queue.size() == 0) begin
                if (gap_left > 0)
                    gap_left--;
                item_if.valid <= 1'b0;
            end else begin
                s = sample_queue.pop_front();
                item_if.valid       <= 1'b1;
                item_if.error_value <= s.err;
                item_if.time_step   <= s.dt;
                if (burst_left > 0) begin
                    burst_left--;
                end else begin
                    burst_left = $urandom_range(0, 24);
                    case ($urandom_range(0, 3))
                        0:       gap_left = $urandom_range(1, 150);
                        1:       gap_left = 0;
                        default: gap_left = $urandom_range(1, 8);
                    endcase
                end
            end
        end
    end

    // Result receiver: stall on a random ready pattern, chosen anew when its run ends
    always @(negedge clk) begin
        if (!rst_n) begin
            result_if.ready <= 1'b0;
        end else begin
            if (stall_armed && !stall_done) begin
                hold_left  = HOLD_CYCLES;
                stall_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                result_if.ready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    mode_left  = $urandom_range(50, 400);
                    ready_mode = t_ready_mode'($urandom_range(0, 3));
                end else begin
                    mode_left--;
                end
                case (ready_mode)
                    RDY_ALWAYS: result_if.ready <= 1'b1;
                    RDY_HALF:   result_if.ready <= ($urandom_range(0, 1) == 0);
                    RDY_SPARSE: result_if.ready <= ($urandom_range(0, 9) == 0);
                    default:    result_if.ready <= ($urandom_range(0, 49) == 0);
                endcase
            end
        end
    end

    // Monitor: predict on each item transfer, check each result transfer
    always @(posedge clk) begin
        t_drive want;
        item_taken = item_if.valid && item_if.ready;
        if (rst_n && item_taken) begin
            drive_queue.push_back(predict_drive(item_if.error_value, item_if.time_step));
            n_accepted++;
        end
        if (rst_n && result_if.valid && result_if.ready) begin
            if (drive_queue.size() == 0) begin
                $display("%0t: unexpected result: drive %h clamped %b", $time,
                         result_if.drive_value, result_if.clamped);
                mismatch_count++;
            end else begin
                want = drive_queue.pop_front();
                if (want.drive !== result_if.drive_value) begin
                    $display("%0t: drive_value expected %h actual %h", $time,
                             want.drive, result_if.drive_value);
                    mismatch_count++;
                end
                if (want.clamped !== result_if.clamped) begin
                    $display("%0t: clamped expected %b actual %b", $time,
                             want.clamped, result_if.clamped);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog: end the run when no transfer happens for too long
    always @(posedge clk) begin
        if (!rst_n || cfg_we || (item_if.valid && item_if.ready)
                || (result_if.valid && result_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog: no transfer for %0d cycles", $time, idle_cycles);
            $display("pid_controller_with_clamp: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        logic [ERR_W-1:0]      e;
        logic [DT_W-1:0]       d;
        logic [CFG_DATA_W-1:0] lo_v, hi_v;

        item_if.valid       = 1'b0;
        item_if.error_value = '0;
        item_if.time_step   = 24'd1;
        result_if.ready     = 1'b0;
        kp       = '0;
        ki       = '0;
        kd       = '0;
        lo_limit = LO_RESET;
        hi_limit = HI_RESET;
        integ    = '0;
        prev_err = '0;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // half gain: rounding ties of both signs, error and time step extremes
        load_config(32'h0000_8000, '0, '0, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_item(32'h0000_0001, 24'h00_0001);
        queue_item(32'hFFFF_FFFF, 24'h00_0001);
        queue_item(32'h7FFF_FFFF, 24'hFF_FFFF);
        queue_item(32'h8000_0000, 24'h00_0001);
        queue_item(32'h0000_0000, 24'h80_0000);
        drain();

        // largest gains, +-100 limits: integral saturation, huge derivative, clamps
        load_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFF9C_0000, 32'h0064_0000);
        queue_item(32'h7FFF_FFFF, 24'hFF_FFFF);
        queue_item(32'h8000_0000, 24'h00_0001);
        queue_item(32'h8000_0000, 24'hFF_FFFF);
        queue_item(32'h8000_0000, 24'hFF_FFFF);
        queue_item(32'h0000_0000, 24'h00_0001);
        queue_item(32'h7FFF_FFFF, 24'h00_0001);
        drain();

        // inverted limits: lower limit tested first
        load_config(32'h0001_0000, '0, '0, 32'h0005_0000, 32'hFFFB_0000);
        queue_item(32'h0010_0000, 24'h00_1000);
        queue_item(32'hFFF0_0000, 24'h00_1000);
        queue_item(32'h0000_0000, 24'h00_1000);
        drain();

        // most negative gains, full-range limits
        load_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
        queue_item(32'h0000_0001, 24'h00_0100);
        queue_item(32'hFFFF_FFFF, 24'h00_0001);
        queue_item(32'h7FFF_FFFF, 24'h00_1000);
        queue_item(32'h5555_5555, 24'hAA_AAAA);
        queue_item(32'hAAAA_AAAA, 24'h55_5555);
        drain();

        // moderate gains, +-256 limits
        load_config(32'h0002_0000, 32'h0000_4000, 32'h0000_0100, 32'hFF00_0000, 32'h0100_0000);
        queue_item(32'h0001_8000, 24'h00_4000);
        queue_item(32'hFFFE_8000, 24'h00_4000);
        queue_item(32'h0000_0000, 24'h00_0001);
        drain();

        // random phases, each with its own gains and limits
        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            case ($urandom_range(0, 4))
                0: begin
                    lo_v = 32'h8000_0000;
                    hi_v = 32'h7FFF_FFFF;
                end
                1: begin
                    lo_v = 32'd0 - $urandom_range(0, 32'h0010_0000);
                    hi_v = $urandom_range(0, 32'h0010_0000);
                end
                2: begin
                    lo_v = $urandom_range(0, 32'h0004_0000);
                    hi_v = 32'd0 - $urandom_range(0, 32'h0004_0000);
                end
                3: begin
                    lo_v = $urandom();
                    hi_v = $urandom();
                end
                default: begin
                    lo_v = $urandom_range(0, 32'h0002_0000) - 32'h0001_0000;
                    hi_v = lo_v;
                end
            endcase
            load_config(pick_gain(), pick_gain(), pick_gain(), lo_v, hi_v);

            // hold the receiver off once so the block backs up into its input
            if (ph == 1)
                stall_armed = 1'b1;

            for (int n = 0; n < PHASE_ITEMS; n++) begin
                case ($urandom_range(0, 9))
                    0:       e = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
                    1, 2:    e = $urandom();
                    default: e = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
                endcase
                case ($urandom_range(0, 7))
                    0:       d = 24'h00_0001;
                    1:       d = 24'hFF_FFFF;
                    2, 3:    d = $urandom_range(1, 24'hFF_FFFF);
                    default: d = $urandom_range(1, 24'h00_4000);
                endcase
                queue_item(e, d);
            end
            drain();
        end

        repeat (200) @(posedge clk);
        if (mismatch_count == 0 && drive_queue.size() == 0)
            $display("pid_controller_with_clamp: match");
        else
            $display("pid_controller_with_clamp: mismatch");
        $finish;
    end

endmodule
